// ===== design/bmphc_pkg.sv =====
`timescale 1ns / 1ps

package bmphc_pkg;

    localparam int HEADER_BYTES        = 54;
    localparam int PALETTE_ENTRY_BYTES = 4;
    localparam int FILE_LEN_W          = 31;
    localparam int PAL_CNT_W           = 11;
    localparam int PIX_CNT_W           = 64;
    localparam int PROD_W              = 63;

    localparam logic [15:0] SIGNATURE   = 16'h4D42;
    localparam logic [31:0] HDR_VERSION = 32'd40;
    localparam logic [31:0] MAX_COLORS  = 32'd256;
    localparam logic [15:0] BPP_PALETTE = 16'd8;
    localparam logic [15:0] BPP_TRUE    = 16'd24;
    localparam logic [15:0] ONE_PLANE   = 16'd1;

    // offset of the last byte of each checked header field
    localparam int LAST_SIGNATURE    = 1;
    localparam int LAST_FILE_SIZE    = 5;
    localparam int LAST_RESERVED     = 9;
    localparam int LAST_PIXEL_OFFSET = 13;
    localparam int LAST_VERSION      = 17;
    localparam int LAST_WIDTH        = 21;
    localparam int LAST_HEIGHT       = 25;
    localparam int LAST_PLANES       = 27;
    localparam int LAST_BPP          = 29;
    localparam int LAST_COMPRESSION  = 33;
    localparam int LAST_IMAGE_SIZE   = 37;
    localparam int LAST_COLORS       = 49;
    localparam int LAST_IMPORTANT    = 53;

    typedef enum logic [3:0] {
        ERR_NONE               = 4'd0,
        ERR_SIGNATURE          = 4'd1,
        ERR_SIZE               = 4'd2,
        ERR_RESERVED           = 4'd3,
        ERR_VERSION            = 4'd4,
        ERR_WIDTH              = 4'd5,
        ERR_HEIGHT             = 4'd6,
        ERR_PLANES             = 4'd7,
        ERR_BPP                = 4'd8,
        ERR_COMPRESSION        = 4'd9,
        ERR_PIXEL_SIZE         = 4'd10,
        ERR_NO_COLORS          = 4'd11,
        ERR_TOO_MANY_COLORS    = 4'd12,
        ERR_COLORS_TRUECOLOR   = 4'd13,
        ERR_TOO_MANY_IMPORTANT = 4'd14
    } err_code_t;

    typedef enum logic [1:0] {
        PH_HEADER  = 2'd0,
        PH_PALETTE = 2'd1,
        PH_PIXELS  = 2'd2,
        PH_DROP    = 2'd3
    } phase_t;

    typedef struct packed {
        err_code_t              err;
        logic                   pal_mode;
        logic [PAL_CNT_W-1:0]   pal_cnt;
        logic [PIX_CNT_W-1:0]   pix_cnt;
    } chk_res_t;

    typedef struct packed {
        logic       busy;
        logic       valid;
        logic [7:0] data;
        logic       last;
    } hdr_rd_t;

endpackage

// ===== design/bmphc_check.sv =====
`timescale 1ns / 1ps

module bmphc_check #(
    parameter int IDX_W = $clog2(bmphc_pkg::HEADER_BYTES)
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               we,
    input  logic [IDX_W-1:0]                   idx,
    input  logic [7:0]                         in_byte,
    input  logic [bmphc_pkg::FILE_LEN_W-1:0]   file_length,
    output bmphc_pkg::chk_res_t                res
);
    import bmphc_pkg::*;

    logic [31:0]          asm_reg, asm_next;
    logic [31:0]          size_reg, size_next;
    logic [31:0]          diff_reg, diff_next;
    logic [30:0]          width_reg, width_next;
    logic [31:0]          rows_reg, rows_next;
    logic [PROD_W-1:0]    prod_reg, prod_next;
    logic                 bpp8_reg, bpp8_next;
    logic                 pal_mode_reg, pal_mode_next;
    logic [PAL_CNT_W-1:0] pal_cnt_reg, pal_cnt_next;
    err_code_t            err_reg, err_next;
    err_code_t            base_err, fail;
    logic [15:0]          f16;

    always_comb
    begin
        asm_next      = asm_reg;
        size_next     = size_reg;
        diff_next     = diff_reg;
        width_next    = width_reg;
        rows_next     = rows_reg;
        prod_next     = prod_reg;
        bpp8_next     = bpp8_reg;
        pal_mode_next = pal_mode_reg;
        pal_cnt_next  = pal_cnt_reg;
        err_next      = err_reg;
        base_err      = err_reg;
        fail          = ERR_NONE;
        f16           = 16'd0;
        if (we)
        begin
            // little-endian: newest byte enters at the top
            asm_next = {in_byte, asm_reg[31:8]};
            f16      = asm_next[31:16];
            base_err = (idx == '0) ? ERR_NONE : err_reg;
            case (idx)
                IDX_W'(LAST_SIGNATURE):
                begin
                    if (f16 != SIGNATURE)
                        fail = ERR_SIGNATURE;
                end
                IDX_W'(LAST_FILE_SIZE):
                begin
                    size_next = asm_next;
                    if (asm_next != {1'b0, file_length})
                        fail = ERR_SIZE;
                end
                IDX_W'(LAST_RESERVED):
                begin
                    if (asm_next != 32'd0)
                        fail = ERR_RESERVED;
                end
                IDX_W'(LAST_PIXEL_OFFSET):
                begin
                    diff_next = size_reg - asm_next;
                end
                IDX_W'(LAST_VERSION):
                begin
                    if (asm_next != HDR_VERSION)
                        fail = ERR_VERSION;
                end
                IDX_W'(LAST_WIDTH):
                begin
                    width_next = asm_next[30:0];
                    if (asm_next[31] || asm_next == 32'd0)
                        fail = ERR_WIDTH;
                end
                IDX_W'(LAST_HEIGHT):
                begin
                    // most negative height gives 2^31 rows as unsigned
                    rows_next = asm_next[31] ? (~asm_next + 32'd1) : asm_next;
                    if (asm_next == 32'd0)
                        fail = ERR_HEIGHT;
                end
                IDX_W'(LAST_PLANES):
                begin
                    prod_next = width_reg * rows_reg;
                    if (f16 != ONE_PLANE)
                        fail = ERR_PLANES;
                end
                IDX_W'(LAST_BPP):
                begin
                    bpp8_next = (f16 == BPP_PALETTE);
                    if (f16 != BPP_PALETTE && f16 != BPP_TRUE)
                        fail = ERR_BPP;
                end
                IDX_W'(LAST_COMPRESSION):
                begin
                    if (asm_next != 32'd0)
                        fail = ERR_COMPRESSION;
                end
                IDX_W'(LAST_IMAGE_SIZE):
                begin
                    if (asm_next != 32'd0 && asm_next != diff_reg)
                        fail = ERR_PIXEL_SIZE;
                end
                IDX_W'(LAST_COLORS):
                begin
                    pal_mode_next = (asm_next != 32'd0) && bpp8_reg;
                    pal_cnt_next  = (pal_mode_next && !asm_next[31]) ?
                                    PAL_CNT_W'({asm_next[8:0], 2'b00}) : '0;
                    if (bpp8_reg)
                    begin
                        if (asm_next == 32'd0)
                            fail = ERR_NO_COLORS;
                        else if (!asm_next[31] && asm_next > MAX_COLORS)
                            fail = ERR_TOO_MANY_COLORS;
                    end
                    else if (asm_next != 32'd0)
                    begin
                        fail = ERR_COLORS_TRUECOLOR;
                    end
                end
                IDX_W'(LAST_IMPORTANT):
                begin
                    if (bpp8_reg && !asm_next[31] && asm_next > MAX_COLORS)
                        fail = ERR_TOO_MANY_IMPORTANT;
                end
                default:
                begin
                end
            endcase
            // first failing check in file order wins
            err_next = (base_err == ERR_NONE) ? fail : base_err;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            err_reg <= ERR_NONE;
        else
            err_reg <= err_next;
    end

    always_ff @(posedge clk)
    begin
        asm_reg      <= asm_next;
        size_reg     <= size_next;
        diff_reg     <= diff_next;
        width_reg    <= width_next;
        rows_reg     <= rows_next;
        prod_reg     <= prod_next;
        bpp8_reg     <= bpp8_next;
        pal_mode_reg <= pal_mode_next;
        pal_cnt_reg  <= pal_cnt_next;
    end

    always_comb
    begin
        res.err      = err_next;
        res.pal_mode = pal_mode_reg;
        res.pal_cnt  = pal_cnt_reg;
        res.pix_cnt  = bpp8_reg ? {1'b0, prod_reg}
                                : ({1'b0, prod_reg} + {prod_reg, 1'b0});
    end

endmodule

// ===== design/bmphc_store.sv =====
`timescale 1ns / 1ps

module bmphc_store #(
    parameter int DEPTH = bmphc_pkg::HEADER_BYTES
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [7:0]               wdata,
    input  logic                     start,
    input  logic                     out_free,
    output bmphc_pkg::hdr_rd_t       rd
);
    import bmphc_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [7:0]    hdr_mem [DEPTH];
    logic [7:0]    rdata_reg;
    logic          rlast_reg;
    logic          active_reg, active_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic          pend_reg, pend_next;
    logic          move, issue, at_end;

    always_comb
    begin
        move   = pend_reg && out_free;
        // refill the read register whenever it is empty or being drained
        issue  = active_reg && (!pend_reg || move);
        at_end = (addr_reg == AW'(DEPTH - 1));

        active_next = active_reg;
        addr_next   = addr_reg;
        pend_next   = pend_reg;
        if (start)
        begin
            active_next = 1'b1;
            addr_next   = '0;
        end
        else if (issue)
        begin
            addr_next = addr_reg + AW'(1);
            if (at_end)
                active_next = 1'b0;
        end
        if (issue)
            pend_next = 1'b1;
        else if (move)
            pend_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            addr_reg   <= '0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            addr_reg   <= addr_next;
            pend_reg   <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
            hdr_mem[waddr] <= wdata;
        if (issue)
        begin
            rdata_reg <= hdr_mem[addr_reg];
            rlast_reg <= at_end;
        end
    end

    always_comb
    begin
        rd.busy  = active_reg || pend_reg;
        rd.valid = pend_reg;
        rd.data  = rdata_reg;
        rd.last  = rlast_reg;
    end

endmodule

// ===== design/bmp_header_check_and_negate_unit.sv =====
// A palette or pixel byte is in the output register in the cycle after its transfer.
// Throughput: one input byte per cycle while the output is free and no header replay runs.
// A header that passes its checks is replayed from the header RAM after its last byte: 54
// bytes, one read port, one byte per cycle while the output is free, each byte going through
// the store's read register to the output register; the input stays stalled until it drains.
// Reset (rst_n, async low) puts the block in header phase with file_length cleared.
`timescale 1ns / 1ps

module bmp_header_check_and_negate_unit #(
    parameter int HEADER_BYTES = bmphc_pkg::HEADER_BYTES
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic [7:0]                       in_byte,
    input  logic                             end_of_file,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic [7:0]                       out_byte,
    output logic [3:0]                       error_code,
    output logic                             last_of_run,
    output logic                             end_of_output,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [bmphc_pkg::FILE_LEN_W-1:0] cfg_data
);
    import bmphc_pkg::*;

    localparam int IDX_W = $clog2(HEADER_BYTES);

    phase_t               phase_reg, phase_next;
    logic [IDX_W-1:0]     idx_reg, idx_next;
    logic                 pal_mode_reg, pal_mode_next;
    logic [PAL_CNT_W-1:0] pal_cnt_reg, pal_cnt_next;
    logic [PIX_CNT_W-1:0] pix_cnt_reg, pix_cnt_next;
    logic [FILE_LEN_W-1:0] file_len_reg, file_len_next;

    logic                 ov_reg, ov_next;
    logic [7:0]           ob_reg, ob_next;
    err_code_t            oe_reg, oe_next;
    logic                 ol_reg, ol_next;
    logic                 oeo_reg, oeo_next;

    logic                 in_acc, out_free, hdr_we, last_hdr, start_emit;
    logic                 direct_load, d_eoo;
    logic [7:0]           d_byte;
    err_code_t            d_err;
    chk_res_t             chk;
    hdr_rd_t              rd;

    assign out_free  = !ov_reg || !out_stall;
    assign in_stall  = rd.busy || !out_free;
    assign in_acc    = in_valid && !in_stall;
    assign hdr_we    = in_acc && (phase_reg == PH_HEADER);
    assign last_hdr  = (idx_reg == IDX_W'(HEADER_BYTES - 1));
    assign cfg_ready = 1'b1;

    bmphc_check #(
        .IDX_W (IDX_W)
    ) u_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .we          (hdr_we),
        .idx         (idx_reg),
        .in_byte     (in_byte),
        .file_length (file_len_reg),
        .res         (chk)
    );

    bmphc_store #(
        .DEPTH (HEADER_BYTES)
    ) u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (hdr_we),
        .waddr    (idx_reg),
        .wdata    (in_byte),
        .start    (start_emit),
        .out_free (out_free),
        .rd       (rd)
    );

    always_comb
    begin
        phase_next    = phase_reg;
        idx_next      = idx_reg;
        pal_mode_next = pal_mode_reg;
        pal_cnt_next  = pal_cnt_reg;
        pix_cnt_next  = pix_cnt_reg;
        file_len_next = cfg_valid ? cfg_data : file_len_reg;
        start_emit    = 1'b0;
        direct_load   = 1'b0;
        d_byte        = 8'd0;
        d_err         = ERR_NONE;
        d_eoo         = 1'b0;
        if (in_acc)
        begin
            case (phase_reg)
                PH_HEADER:
                begin
                    if (last_hdr)
                    begin
                        idx_next = '0;
                        if (chk.err != ERR_NONE)
                        begin
                            direct_load = 1'b1;
                            d_err       = chk.err;
                            d_eoo       = 1'b1;
                            phase_next  = PH_DROP;
                        end
                        else
                        begin
                            start_emit    = 1'b1;
                            pal_mode_next = chk.pal_mode;
                            pal_cnt_next  = chk.pal_cnt;
                            pix_cnt_next  = chk.pix_cnt;
                            phase_next    = (chk.pal_cnt != '0) ? PH_PALETTE : PH_PIXELS;
                        end
                    end
                    else
                    begin
                        idx_next = idx_reg + IDX_W'(1);
                    end
                end
                PH_PALETTE:
                begin
                    // remaining count tells the position in the entry; fourth byte passes
                    direct_load  = 1'b1;
                    d_byte       = ((pal_cnt_reg % PAL_CNT_W'(PALETTE_ENTRY_BYTES))
                                    == PAL_CNT_W'(1)) ? in_byte : ~in_byte;
                    pal_cnt_next = pal_cnt_reg - PAL_CNT_W'(1);
                    if (pal_cnt_reg == PAL_CNT_W'(1))
                        phase_next = PH_PIXELS;
                end
                PH_PIXELS:
                begin
                    direct_load  = 1'b1;
                    d_byte       = pal_mode_reg ? in_byte : ~in_byte;
                    d_eoo        = (pix_cnt_reg == PIX_CNT_W'(1));
                    pix_cnt_next = pix_cnt_reg - PIX_CNT_W'(1);
                    if (d_eoo)
                        phase_next = PH_DROP;
                end
                default:
                begin
                end
            endcase
            if (end_of_file)
            begin
                phase_next    = PH_HEADER;
                idx_next      = '0;
                pal_mode_next = 1'b0;
            end
        end
    end

    // output register: direct results and header replay never collide
    always_comb
    begin
        ov_next  = ov_reg;
        ob_next  = ob_reg;
        oe_next  = oe_reg;
        ol_next  = ol_reg;
        oeo_next = oeo_reg;
        if (direct_load)
        begin
            ov_next  = 1'b1;
            ob_next  = d_byte;
            oe_next  = d_err;
            ol_next  = 1'b1;
            oeo_next = d_eoo;
        end
        else if (rd.valid && out_free)
        begin
            ov_next  = 1'b1;
            ob_next  = rd.data;
            oe_next  = ERR_NONE;
            ol_next  = rd.last;
            oeo_next = 1'b0;
        end
        else if (!out_stall)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            idx_reg      <= '0;
            pal_mode_reg <= 1'b0;
            file_len_reg <= '0;
            ov_reg       <= 1'b0;
        end
        else
        begin
            phase_reg    <= phase_next;
            idx_reg      <= idx_next;
            pal_mode_reg <= pal_mode_next;
            file_len_reg <= file_len_next;
            ov_reg       <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pal_cnt_reg <= pal_cnt_next;
        pix_cnt_reg <= pix_cnt_next;
        ob_reg      <= ob_next;
        oe_reg      <= oe_next;
        ol_reg      <= ol_next;
        oeo_reg     <= oeo_next;
    end

    assign out_valid     = ov_reg;
    assign out_byte      = ob_reg;
    assign error_code    = oe_reg;
    assign last_of_run   = ol_reg;
    assign end_of_output = oeo_reg;

    a_err_result_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oe_reg != ERR_NONE) |-> (oeo_reg && ol_reg && ob_reg == 8'd0))
        else $error("error result malformed");

    a_eoo_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        (ov_reg && oeo_reg) |-> ol_reg)
        else $error("end_of_output without last_of_run");

    a_pixel_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PIXELS) |-> (pix_cnt_reg != '0))
        else $error("pixel phase with zero count");

    a_palette_count_live: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_PALETTE) |-> (pal_cnt_reg != '0))
        else $error("palette phase with zero count");

endmodule
